### rtl/lcgsub_pkg.sv
// ----------------------------------------------------------------------------
// lcgsub_pkg
// Shared constants and types for the LCG letter substitution block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgsub_pkg;

    localparam int CHAR_W  = 8;
    localparam int STATE_W = 48;
    localparam int DRAW_W  = 32;
    localparam int REM_W   = 5;

    // generator multiplier, split for the partial products
    localparam logic [STATE_W-1:0] LCG_MUL    = 48'h0005_DEEC_E66D;
    localparam logic [31:0]        LCG_MUL_LO = 32'hDEEC_E66D;
    localparam logic [2:0]         LCG_MUL_HI = 3'h5;
    localparam logic [STATE_W-1:0] LCG_ADD    = 48'h0000_0000_000B;
    localparam logic [STATE_W-1:0] SEED_RESET = 48'h0000_0000_0004;

    localparam logic [5:0]        NUM_LETTERS = 6'd26;
    localparam logic [CHAR_W-1:0] LETTER_A    = 8'h61;

    typedef struct packed {
        logic       latch_item;   // hold the accepted item for a line start
        logic       emit_direct;  // result from the item on the port
        logic       emit_held;    // result from the held item
        logic       mul_step;     // partial products of the generator step
        logic       add_step;     // sum partial products into the state
        logic       abs_step;     // magnitude of the signed draw
        logic       mod_step;     // one byte of the remainder by 26
        logic       mod_first;    // first byte: remainder starts at zero
        logic [1:0] mod_byte;     // byte index, most significant first
        logic       store_from;   // write the letter to replace
        logic       store_to;     // write its replacement
    } cmd_t;

endpackage : lcgsub_pkg

`default_nettype wire

### rtl/lcgsub_if.sv
// ----------------------------------------------------------------------------
// lcgsub_if
// Valid/ready channel interfaces: input items, result items, seed writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcgsub_in_if;
    import lcgsub_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              starts_line;
    logic              has_char;

    modport source (output valid, output char_code, output starts_line,
                    output has_char, input ready);
    modport sink   (input valid, input char_code, input starts_line,
                    input has_char, output ready);
endinterface : lcgsub_in_if

interface lcgsub_out_if;
    import lcgsub_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              was_replaced;

    modport source (output valid, output out_char, output was_replaced,
                    input ready);
    modport sink   (input valid, input out_char, input was_replaced,
                    output ready);
endinterface : lcgsub_out_if

interface lcgsub_cfg_if;
    import lcgsub_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] seed_value;

    modport source (output valid, output seed_value, input ready);
    modport sink   (input valid, input seed_value, output ready);
endinterface : lcgsub_cfg_if

`default_nettype wire

### rtl/lcgsub_ctrl.sv
// ----------------------------------------------------------------------------
// lcgsub_ctrl
// Sequencer for the two draws of a line start and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgsub_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_starts_line,
    input  wire logic          in_has_char,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lcgsub_pkg::cmd_t   cmd
);
    import lcgsub_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_ABS  = 3'd3;
    localparam logic [2:0] ST_MOD  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       draw_sel_reg, draw_sel_next;   // 0: from letter, 1: to letter
    logic [1:0] byte_cnt_reg, byte_cnt_next;
    logic       has_reg, has_next;
    logic       out_valid_reg, out_valid_next;

    logic slot_free;
    logic in_xfer;
    logic emit;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign emit      = cmd.emit_direct || cmd.emit_held;

    always_comb
    begin
        state_next    = state_reg;
        draw_sel_next = draw_sel_reg;
        byte_cnt_next = byte_cnt_reg;
        has_next      = has_reg;
        cmd           = '0;
        cmd.mod_byte  = byte_cnt_reg;
        cmd.mod_first = (byte_cnt_reg == 2'd0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_starts_line)
                    begin
                        cmd.latch_item = 1'b1;
                        has_next       = in_has_char;
                        draw_sel_next  = 1'b0;
                        state_next     = ST_MUL;
                    end
                    else if (in_has_char)
                    begin
                        cmd.emit_direct = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add_step = 1'b1;
                state_next   = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.abs_step  = 1'b1;
                byte_cnt_next = 2'd0;
                state_next    = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod_step  = 1'b1;
                byte_cnt_next = byte_cnt_reg + 2'd1;
                if (byte_cnt_reg == 2'd3)
                begin
                    cmd.store_from = !draw_sel_reg;
                    cmd.store_to   = draw_sel_reg;
                    if (!draw_sel_reg)
                    begin
                        draw_sel_next = 1'b1;
                        state_next    = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!has_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    cmd.emit_held = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            draw_sel_reg  <= 1'b0;
            byte_cnt_reg  <= 2'd0;
            has_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            draw_sel_reg  <= draw_sel_next;
            byte_cnt_reg  <= byte_cnt_next;
            has_reg       <= has_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : lcgsub_ctrl

`default_nettype wire

### rtl/lcgsub_dp.sv
// ----------------------------------------------------------------------------
// lcgsub_dp
// Generator state, split 48-bit multiply, remainder by 26, letter compare.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgsub_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lcgsub_pkg::cmd_t                cmd,
    input  wire logic                            cfg_we,
    input  wire logic [lcgsub_pkg::STATE_W-1:0]  cfg_seed,
    input  wire logic [lcgsub_pkg::CHAR_W-1:0]   in_char,
    output logic      [lcgsub_pkg::CHAR_W-1:0]   out_char,
    output logic                                 out_replaced
);
    import lcgsub_pkg::*;

    logic [STATE_W-1:0] rng_reg, rng_next;
    logic [STATE_W-1:0] p0_reg;
    logic [15:0]        p1_reg;
    logic [DRAW_W-1:0]  mag_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [CHAR_W-1:0]  from_reg, to_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_replaced_reg;

    logic [63:0]        prod_lo;
    logic [15:0]        prod_cross;
    logic [DRAW_W-1:0]  draw;
    logic [CHAR_W-1:0]  mod_byte_val;
    logic [REM_W-1:0]   rem_w;
    logic [5:0]         acc;
    logic [CHAR_W-1:0]  letter;
    logic [CHAR_W-1:0]  cmp_char;
    logic               hit;

    // state mod 2^48 = lo*MLO + ((hi*MLO + lo*MHI) << 32), upper cross terms dropped
    assign prod_lo    = rng_reg[31:0] * LCG_MUL_LO;
    assign prod_cross = 16'(rng_reg[47:32] * LCG_MUL_LO[15:0])
                      + 16'(rng_reg[15:0] * {13'd0, LCG_MUL_HI});

    always_comb
    begin
        priority if (cmd.add_step)
            rng_next = p0_reg + {p1_reg, 32'd0} + LCG_ADD;
        else if (cfg_we)
            rng_next = cfg_seed ^ LCG_MUL;
        else
            rng_next = rng_reg;
    end

    assign draw = rng_reg[47:16];

    always_comb
    begin
        unique case (cmd.mod_byte)
            2'd0:    mod_byte_val = mag_reg[31:24];
            2'd1:    mod_byte_val = mag_reg[23:16];
            2'd2:    mod_byte_val = mag_reg[15:8];
            2'd3:    mod_byte_val = mag_reg[7:0];
            default: mod_byte_val = mag_reg[7:0];
        endcase
    end

    // eight restoring steps of the remainder, one bit each
    always_comb
    begin
        rem_w = cmd.mod_first ? '0 : rem_reg;
        acc   = '0;
        for (int i = CHAR_W - 1; i >= 0; i--)
        begin
            acc = {rem_w, mod_byte_val[i]};
            if (acc >= NUM_LETTERS)
                acc = acc - NUM_LETTERS;
            rem_w = acc[REM_W-1:0];
        end
    end

    assign letter   = LETTER_A + {3'd0, rem_w};
    assign cmp_char = cmd.emit_held ? char_reg : in_char;
    assign hit      = (cmp_char == from_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg  <= SEED_RESET ^ LCG_MUL;
            from_reg <= '0;
            to_reg   <= '0;
        end
        else
        begin
            rng_reg <= rng_next;
            if (cmd.store_from)
                from_reg <= letter;
            if (cmd.store_to)
                to_reg <= letter;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step)
        begin
            p0_reg <= prod_lo[STATE_W-1:0];
            p1_reg <= prod_cross;
        end
        if (cmd.abs_step)
            mag_reg <= draw[DRAW_W-1] ? (32'd0 - draw) : draw;
        if (cmd.mod_step)
            rem_reg <= rem_w;
        if (cmd.latch_item)
            char_reg <= in_char;
        if (cmd.emit_direct || cmd.emit_held)
        begin
            out_char_reg     <= hit ? to_reg : cmp_char;
            out_replaced_reg <= hit;
        end
    end

    assign out_char     = out_char_reg;
    assign out_replaced = out_replaced_reg;

endmodule : lcgsub_dp

`default_nettype wire

### rtl/lcg_random_letter_substitution_unit.sv
// ----------------------------------------------------------------------------
// lcg_random_letter_substitution_unit
// Letter substitution driven by a 48-bit linear congruential generator.
// ----------------------------------------------------------------------------
// An item without a line start is taken while the sequencer is idle; if it
// carries a character, its result lands in the output register, so a character
// stream runs at one item per cycle while the result side keeps up. An item
// that starts a line holds the input from its transfer to the next transfer:
// two draws (each the 48-bit generator multiply as a 32x32 partial product
// plus cross terms, the sum into the state, the draw magnitude, and four steps
// of the remainder by 26 at one byte per cycle), then an emit state that
// delivers its result, or just returns to idle for an empty line. A stalled
// result side adds its stall cycles on top. Seed writes belong between items,
// while nothing is in flight; each reloads the generator.
`default_nettype none

module lcg_random_letter_substitution_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lcgsub_in_if.sink   item,
    lcgsub_out_if.source result,
    lcgsub_cfg_if.sink  cfg
);
    import lcgsub_pkg::*;

    cmd_t cmd;
    logic cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    lcgsub_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (item.valid),
        .in_starts_line (item.starts_line),
        .in_has_char    (item.has_char),
        .in_ready       (item.ready),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .cmd            (cmd)
    );

    lcgsub_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_seed     (cfg.seed_value),
        .in_char      (item.char_code),
        .out_char     (result.out_char),
        .out_replaced (result.was_replaced)
    );

endmodule : lcg_random_letter_substitution_unit

`default_nettype wire
